### rtl/core/assert_macros.svh
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define FQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define FQS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/core/fqs_pkg.sv
// Constants, types and helper functions for the searchable queue.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 5;
  localparam int POS_BITS   = 8;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;
  localparam int CMP_W      = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  typedef logic [PTR_W-1:0]            ptr_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ENQ      = 4'd0,
    OP_DEQ      = 4'd1,
    OP_FRONT    = 4'd2,
    OP_REAR     = 4'd3,
    OP_CONTAINS = 4'd4,
    OP_COUNT    = 4'd5,
    OP_GETAT    = 4'd6,
    OP_NTH      = 4'd7,
    OP_MAX      = 4'd8,
    OP_MIN      = 4'd9,
    OP_REVERSE  = 4'd10,
    OP_CLEAR    = 4'd11,
    OP_SIZE     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  // Control from the sequencer to the scan accumulator
  typedef struct packed {
    logic beat;
    logic first;
    logic find_max;
  } scan_ctl_t;

  // Running results of a scan
  typedef struct packed {
    cnt_t  count;
    word_t best;
  } scan_res_t;

  // Add two ring indexes modulo DEPTH
  function automatic ptr_t wrap_add(input ptr_t a, input ptr_t b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // Ring slot of a logical position counted from the front
  function automatic ptr_t slot_of(input ptr_t head, input cnt_t occ, input logic rev,
                                   input cnt_t lpos);
    cnt_t off;
    off = rev ? (occ - cnt_t'(1) - lpos) : lpos;
    return wrap_add(head, off[PTR_W-1:0]);
  endfunction

endpackage

### rtl/core/fqs_chan_if.sv
// Request and response channel interfaces of the searchable queue.
`timescale 1ns / 1ps

interface fqs_in_if;
  import fqs_pkg::*;

  logic                valid;
  logic                ready;
  logic [3:0]          opcode;
  word_t               value;
  logic [POS_BITS-1:0] position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface fqs_out_if;
  import fqs_pkg::*;

  logic                  valid;
  logic                  ready;
  word_t                 data;
  logic                  found;
  logic [COUNT_BITS-1:0] match_count;
  logic [COUNT_BITS-1:0] fill_level;
  logic [1:0]            status;

  modport source (output valid, data, found, match_count, fill_level, status, input ready);
  modport sink   (input valid, data, found, match_count, fill_level, status, output ready);
endinterface

### rtl/core/fqs_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module fqs_ram #(
  parameter int N_ENTRIES = 16,
  parameter int DATA_W    = 32,
  localparam int AW       = (N_ENTRIES > 1) ? $clog2(N_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [N_ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/fqs_scan.sv
// Scan accumulator: match count and running maximum or minimum.
`timescale 1ns / 1ps

module fqs_scan (
  input  logic              clk,
  input  fqs_pkg::scan_ctl_t ctl,
  input  fqs_pkg::word_t    rd_data,
  input  fqs_pkg::word_t    key,
  output fqs_pkg::scan_res_t res
);
  import fqs_pkg::*;

  cnt_t  count_r;
  cnt_t  count_nxt;
  word_t best_r;
  word_t best_nxt;
  logic  hit;
  logic  take;

  // Fold one word read from the ring into the running results
  always_comb begin
    hit       = (rd_data == key);
    take      = ctl.first || (ctl.find_max ? (rd_data > best_r) : (rd_data < best_r));
    count_nxt = ctl.first ? cnt_t'(hit) : (count_r + cnt_t'(hit));
    best_nxt  = take ? rd_data : best_r;
  end

  // Advance on each returned word
  always_ff @(posedge clk) begin
    if (ctl.beat) begin
      count_r <= count_nxt;
      best_r  <= best_nxt;
    end
  end

  assign res.count = count_r;
  assign res.best  = best_r;

endmodule

### rtl/core/fifo_queue_with_search.sv
// Top level of the searchable queue: sequencer, pointers and result register.
//
//  Channel   Dir  Handshake            Payload
//  in_chan   in   valid / ready        opcode, value, position
//  out_chan  out  valid / ready        data, found, match_count, fill_level, status
//
// Enqueue, reverse, clear, size and every refused item complete in the idle state.
// Dequeue, front, rear, getat and nthfromend make one RAM read and load in the read state.
// Contains, count, max and min scan the ring, one word per cycle through the single read
// port of the entry RAM; they answer without a scan when the queue is empty.
// Reset is synchronous; the entry RAM is never cleared.
// A new item is taken only when the result register is empty or being drained.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fifo_queue_with_search (
  input logic       clk,
  input logic       rst_n,
  fqs_in_if.sink    in_chan,
  fqs_out_if.source out_chan
);
  import fqs_pkg::*;

  // Sequencer and queue state
  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  cnt_t   occ_r, occ_nxt;
  logic   rev_r, rev_nxt;
  op_t    op_r, op_nxt;
  word_t  key_r, key_nxt;
  cnt_t   iss_cnt_r, iss_cnt_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  logic   rd_first_r, rd_first_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  word_t                 out_data_r, out_data_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [COUNT_BITS-1:0] out_match_r, out_match_nxt;
  logic [COUNT_BITS-1:0] out_fill_r, out_fill_nxt;
  status_t               out_status_r, out_status_nxt;

  // Handshake and decode
  logic             in_ready_s;
  logic             acc;
  op_t              op_in;
  logic             empty;
  logic             full;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] occ_w;
  logic             dec_read;
  logic             dec_scan;
  cnt_t             dec_lpos;

  // RAM and scan
  logic      ram_wr_en;
  ptr_t      ram_wr_addr;
  logic      ram_rd_en;
  ptr_t      ram_rd_addr;
  word_t     ram_rd_data;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  // Result load
  logic    ld;
  word_t   ld_data;
  logic    ld_found;
  cnt_t    ld_match;
  status_t ld_status;

  assign in_ready_s = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign acc        = in_chan.valid && in_ready_s;
  assign op_in      = op_t'(in_chan.opcode);

  // Decode which items read one entry and which scan the ring
  always_comb begin
    empty    = (occ_r == '0);
    full     = (occ_r == cnt_t'(DEPTH));
    pos_w    = CMP_W'(in_chan.position);
    occ_w    = CMP_W'(occ_r);
    dec_read = 1'b0;
    dec_scan = 1'b0;
    dec_lpos = '0;
    unique case (op_in) inside
      OP_DEQ, OP_FRONT: begin
        dec_read = !empty;
      end
      OP_REAR: begin
        dec_read = !empty;
        dec_lpos = occ_r - cnt_t'(1);
      end
      OP_GETAT: begin
        dec_read = (pos_w < occ_w);
        dec_lpos = cnt_t'(in_chan.position);
      end
      OP_NTH: begin
        dec_read = (pos_w != '0) && (pos_w <= occ_w);
        dec_lpos = occ_r - cnt_t'(in_chan.position);
      end
      OP_CONTAINS, OP_COUNT, OP_MAX, OP_MIN: begin
        dec_scan = !empty;
      end
      default: begin
        dec_read = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && dec_read) begin
          state_nxt = S_READ;
        end else if (acc && dec_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if ((iss_cnt_r == occ_r) && !rd_pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs: pointer updates, RAM accesses and result load
  always_comb begin
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    rev_nxt      = rev_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    iss_cnt_nxt  = iss_cnt_r;
    rd_pend_nxt  = 1'b0;
    rd_first_nxt = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;
    ld           = 1'b0;
    ld_data      = '0;
    ld_found     = 1'b0;
    ld_match     = '0;
    ld_status    = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt  = op_in;
          key_nxt = in_chan.value;
          if (dec_read) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_of(head_r, occ_r, rev_r, dec_lpos);
          end
          if (dec_scan) begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = head_r;
            iss_cnt_nxt  = cnt_t'(1);
            rd_pend_nxt  = 1'b1;
            rd_first_nxt = 1'b1;
          end
          case (op_in) inside
            OP_ENQ: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                ram_wr_en = 1'b1;
                if (rev_r) begin
                  head_nxt    = (head_r == '0) ? ptr_t'(DEPTH - 1) : (head_r - ptr_t'(1));
                  ram_wr_addr = head_nxt;
                end else begin
                  ram_wr_addr = wrap_add(head_r, occ_r[PTR_W-1:0]);
                end
                occ_nxt = occ_r + cnt_t'(1);
              end
            end
            OP_DEQ: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                if (!rev_r) begin
                  head_nxt = wrap_add(head_r, ptr_t'(1));
                end
                occ_nxt = occ_r - cnt_t'(1);
              end
            end
            OP_FRONT, OP_REAR, OP_MAX, OP_MIN: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end
            end
            OP_GETAT, OP_NTH: begin
              if (!dec_read) begin
                ld        = 1'b1;
                ld_status = ST_RANGE;
              end
            end
            OP_CONTAINS, OP_COUNT: begin
              ld = empty;
            end
            OP_REVERSE: begin
              rev_nxt = !rev_r;
              ld      = 1'b1;
            end
            OP_CLEAR: begin
              head_nxt = '0;
              occ_nxt  = '0;
              rev_nxt  = 1'b0;
              ld       = 1'b1;
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        ld      = 1'b1;
        ld_data = ram_rd_data;
      end
      S_SCAN: begin
        // Issue one ring read per cycle until every entry is requested
        if (iss_cnt_r < occ_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = wrap_add(head_r, iss_cnt_r[PTR_W-1:0]);
          iss_cnt_nxt = iss_cnt_r + cnt_t'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      S_DONE: begin
        ld = 1'b1;
        case (op_r) inside
          OP_CONTAINS: ld_found = (scan_res.count != '0);
          OP_COUNT:    ld_match = scan_res.count;
          OP_MAX, OP_MIN: ld_data = scan_res.best;
          default:     ld_data = '0;
        endcase
      end
      default: begin
        ld = 1'b0;
      end
    endcase

    // Hold or drain the result register, load on completion
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_match_nxt  = out_match_r;
    out_fill_nxt   = out_fill_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    if (ld) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = ld_data;
      out_found_nxt  = ld_found;
      out_match_nxt  = COUNT_BITS'(ld_match);
      out_fill_nxt   = COUNT_BITS'(occ_nxt);
      out_status_nxt = ld_status;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      iss_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      rd_first_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      rev_r       <= rev_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_first_r  <= rd_first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_match_r  <= out_match_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
  end

  // Scan beats come in the cycle after each read, when the RAM data is registered
  assign scan_ctl.beat     = rd_pend_r;
  assign scan_ctl.first    = rd_first_r;
  assign scan_ctl.find_max = (op_r == OP_MAX);

  fqs_ram #(
    .N_ENTRIES (DEPTH),
    .DATA_W    (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (key_nxt),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  fqs_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rd_data (ram_rd_data),
    .key     (key_r),
    .res     (scan_res)
  );

  assign in_chan.ready        = in_ready_s;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.data        = out_data_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.match_count = out_match_r;
  assign out_chan.fill_level  = out_fill_r;
  assign out_chan.status      = out_status_r;

  `FQS_ASSERT(a_occ_bound, occ_r <= cnt_t'(DEPTH), "occupancy above depth")
  `FQS_ASSERT(a_read_slot_free, (state_r == S_READ) |-> !out_valid_r, "result slot busy on read")
  `FQS_ASSERT(a_scan_drained, (state_r == S_DONE) |-> (!rd_pend_r && iss_cnt_r == occ_r),
              "scan finished with reads outstanding")
  `FQS_ASSERT(a_head_hold, (state_r != S_IDLE) |=> $stable(head_r), "head moved while busy")
  `FQS_NEVER(a_wr_idle_only, ram_wr_en && state_r != S_IDLE, "entry write outside idle")

endmodule

### dv/testbench.sv
// Self-checking testbench for the searchable queue: random and directed items, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import fqs_pkg::*;

  localparam int          CLK_HALF       = 4;
  localparam int          RESET_CYCLES   = 6;
  localparam int          RANDOM_ITEMS   = 1900;
  localparam int          CALM_ITEMS     = 200;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          MAX_PRINTS     = 40;
  localparam logic [3:0]  OP_SPARE_FIRST = 4'd13;
  localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;

  typedef struct {
    word_t                 data;
    logic                  found;
    logic [COUNT_BITS-1:0] match_count;
    logic [COUNT_BITS-1:0] fill_level;
    logic [1:0]            status;
  } queue_resp_t;

  // Mirror of the queue state plus the results still owed by the block
  class queue_checker;
    word_t       ring[DEPTH];
    int          head;
    int          occ;
    bit          rev;
    queue_resp_t owed[$];
    int          errors;

    function new();
      head   = 0;
      occ    = 0;
      rev    = 0;
      errors = 0;
    endfunction

    function int slot(int p);
      int off;
      off = rev ? (occ - 1 - p) : p;
      return (head + off) % DEPTH;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one operation to the mirror and return the result it causes
    function queue_resp_t predict_queue_op(logic [3:0] op, word_t val, logic [POS_BITS-1:0] pos);
      queue_resp_t r;
      int          hits;
      word_t       best;
      r.data        = '0;
      r.found       = 1'b0;
      r.match_count = '0;
      r.status      = ST_OK;
      hits          = 0;
      case (op)
        OP_ENQ: begin
          if (occ >= DEPTH) begin
            r.status = ST_FULL;
          end else if (rev) begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = val;
            occ++;
          end else begin
            ring[(head + occ) % DEPTH] = val;
            occ++;
          end
        end
        OP_DEQ: begin
          if (occ == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = ring[slot(0)];
            if (!rev) head = (head + 1) % DEPTH;
            occ--;
          end
        end
        OP_FRONT, OP_REAR: begin
          if (occ == 0) r.status = ST_EMPTY;
          else r.data = ring[slot((op == OP_FRONT) ? 0 : occ - 1)];
        end
        OP_CONTAINS, OP_COUNT: begin
          for (int i = 0; i < occ; i++) begin
            if (ring[slot(i)] == val) hits++;
          end
          if (op == OP_CONTAINS) r.found = (hits != 0);
          else r.match_count = COUNT_BITS'(hits);
        end
        OP_GETAT: begin
          if (int'(pos) >= occ) r.status = ST_RANGE;
          else r.data = ring[slot(int'(pos))];
        end
        OP_NTH: begin
          if (pos == 0 || int'(pos) > occ) r.status = ST_RANGE;
          else r.data = ring[slot(occ - int'(pos))];
        end
        OP_MAX, OP_MIN: begin
          if (occ == 0) begin
            r.status = ST_EMPTY;
          end else begin
            best = ring[slot(0)];
            for (int i = 1; i < occ; i++) begin
              if (op == OP_MAX ? (ring[slot(i)] > best) : (ring[slot(i)] < best)) begin
                best = ring[slot(i)];
              end
            end
            r.data = best;
          end
        end
        OP_REVERSE: rev = !rev;
        OP_CLEAR: begin
          occ  = 0;
          head = 0;
          rev  = 0;
        end
        default: ;
      endcase
      r.fill_level = COUNT_BITS'(occ);
      return r;
    endfunction

    function void note_request(logic [3:0] op, word_t val, logic [POS_BITS-1:0] pos);
      owed.push_back(predict_queue_op(op, val, pos));
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_response(queue_resp_t got);
      queue_resp_t exp;
      if (owed.size() == 0) begin
        report("result arrived with none outstanding");
        return;
      end
      exp = owed.pop_front();
      if (got.data !== exp.data)
        report($sformatf("data got %0d want %0d", got.data, exp.data));
      if (got.found !== exp.found)
        report($sformatf("found got %0b want %0b", got.found, exp.found));
      if (got.match_count !== exp.match_count)
        report($sformatf("match_count got %0d want %0d", got.match_count, exp.match_count));
      if (got.fill_level !== exp.fill_level)
        report($sformatf("fill_level got %0d want %0d", got.fill_level, exp.fill_level));
      if (got.status !== exp.status)
        report($sformatf("status got %0d want %0d", got.status, exp.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent;

  fqs_in_if  in_ch ();
  fqs_out_if out_ch ();

  queue_checker sb = new();

  fifo_queue_with_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  // Check every item taken from the result channel
  always @(posedge clk) begin
    queue_resp_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data        = out_ch.data;
      got.found       = out_ch.found;
      got.match_count = out_ch.match_count;
      got.fill_level  = out_ch.fill_level;
      got.status      = out_ch.status;
      sb.check_response(got);
    end
  end

  // Stall the result channel in random bursts, never once calm
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // Offer one item, optionally after an idle burst, and hold it until taken
  task automatic send_item(logic [3:0] op, word_t val, logic [POS_BITS-1:0] pos);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.opcode   = op;
    in_ch.value    = val;
    in_ch.position = pos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, val, pos);
    sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic word_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 9 && sb.occ > 0) return sb.ring[sb.slot($urandom_range(0, sb.occ - 1))];
    if (sel < 4) return word_t'($urandom_range(0, 6)) - 32'sd3;
    if (sel < 5) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return word_t'($urandom());
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return POS_BITS'($urandom_range(0, sb.occ + 1));
    if (sel < 8) return POS_BITS'($urandom_range(0, 255));
    return POS_BITS'($urandom_range(0, 3));
  endfunction

  function automatic logic [3:0] pick_opcode();
    int w;
    w = $urandom_range(0, 99);
    if (w < 22) return OP_ENQ;
    if (w < 38) return OP_DEQ;
    if (w < 44) return OP_FRONT;
    if (w < 50) return OP_REAR;
    if (w < 56) return OP_CONTAINS;
    if (w < 62) return OP_COUNT;
    if (w < 70) return OP_GETAT;
    if (w < 78) return OP_NTH;
    if (w < 83) return OP_MAX;
    if (w < 88) return OP_MIN;
    if (w < 92) return OP_REVERSE;
    if (w < 94) return OP_CLEAR;
    if (w < 97) return OP_SIZE;
    return 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  // Stimulus
  initial begin
    int    kind;
    int    extra;
    word_t fill_val;
    bit    same_val;

    calm           = 1'b0;
    sent           = 0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = '0;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty-queue statuses, extreme words, range errors, reverse, spares
    send_item(OP_DEQ, 0, 0);
    send_item(OP_FRONT, 0, 0);
    send_item(OP_MAX, 0, 0);
    send_item(OP_MIN, 0, 0);
    send_item(OP_GETAT, 0, 0);
    send_item(OP_NTH, 0, 1);
    send_item(OP_COUNT, 0, 0);
    send_item(OP_ENQ, 32'sh7fffffff, 0);
    send_item(OP_ENQ, 32'sh80000000, 0);
    send_item(OP_ENQ, 0, 0);
    send_item(OP_ENQ, -1, 0);
    send_item(OP_MAX, 0, 0);
    send_item(OP_MIN, 0, 0);
    send_item(OP_GETAT, 0, 8'hff);
    send_item(OP_NTH, 0, 0);
    send_item(OP_NTH, 0, 4);
    send_item(OP_COUNT, -1, 0);
    send_item(OP_CONTAINS, 5, 0);
    send_item(OP_REVERSE, 0, 0);
    send_item(OP_FRONT, 0, 0);
    send_item(OP_REAR, 0, 0);
    send_item(OP_DEQ, 0, 0);
    send_item(OP_SIZE, 0, 0);
    send_item(OP_SPARE_FIRST, 32'sh5a5a5a5a, 8'haa);
    send_item(OP_SPARE_LAST, 0, 0);
    send_item(OP_CLEAR, 0, 0);
    wait_drained();

    // Random: fill and drain runs mixed with single operations
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        // fill to full, then push against the limit
        same_val = ($urandom_range(0, 2) == 0);
        fill_val = pick_value();
        while (sb.occ < DEPTH) begin
          send_item(OP_ENQ, same_val ? fill_val : pick_value(), pick_position());
        end
        extra = $urandom_range(1, 2);
        repeat (extra) send_item(OP_ENQ, pick_value(), pick_position());
      end else if (kind < 20) begin
        // drain to empty, then one past it
        while (sb.occ > 0) begin
          send_item(($urandom_range(0, 3) == 0) ? OP_NTH : OP_DEQ, pick_value(),
                    pick_position());
          if (in_ch.opcode == OP_NTH) send_item(OP_DEQ, 0, 0);
        end
        send_item(OP_DEQ, pick_value(), pick_position());
      end else if (kind < 23 && !calm) begin
        wait_drained();
      end else begin
        send_item(pick_opcode(), pick_value(), pick_position());
      end
    end

    // Let the block settle and catch any stray results
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
